FILE: sv/fnv1a_linear_probe_hash_table_top_macros.svh
// Assertion macros for the hash table block.
`ifndef FNV1A_LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define FNV1A_LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FNVLPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FNVLPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FNVLPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FNVLPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/fnvlph_pkg.sv
// Shared types, constants and hash helper for the hash table block.
package fnvlph_pkg;

    // default configuration
    localparam int SLOTS_DEF      = 1024;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;

    // key length counter width (0..8 bytes)
    localparam int LEN_W = 4;

    // FNV-1a 64-bit constants; prime = 2^40 + 0x1B3
    localparam logic [63:0] FNV_BASIS     = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;
    localparam int          FNV_PRIME_SH  = 40;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result status codes
    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_REPLACED  = 3'd1;
    localparam logic [2:0] STAT_FOUND     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_ZERO_VAL  = 3'd5;

    // main sequencer
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_PROBE,
        ST_RESP
    } t_state;

    // hash unit sequencer
    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MIX,
        HS_MOD,
        HS_DONE
    } t_hash_state;

    // memory access controls
    typedef struct packed {
        logic rd;
        logic wr_tag;
        logic wr_val;
        logic clr;
    } t_store_ctl;

    // one FNV-1a round: xor the byte in, multiply by the prime
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_PRIME_SH) + (x * FNV_PRIME_LOW);
    endfunction

endpackage

FILE: sv/fnvlph_hash.sv
// FNV-1a hash unit, one key byte per cycle, then reduction to a home slot.
module fnvlph_hash #(
    parameter int SLOTS     = fnvlph_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = fnvlph_pkg::KEY_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [8*KEY_BYTES-1:0]              i_key,
    input  logic [fnvlph_pkg::LEN_W-1:0]        i_len,
    output logic                                o_done,
    output logic [$clog2(SLOTS)-1:0]            o_home
);

    localparam int KW        = 8 * KEY_BYTES;
    localparam int SW        = $clog2(SLOTS);
    localparam bit IS_POW2   = (SLOTS & (SLOTS - 1)) == 0;
    // two steps per hash byte: quotient estimate, then subtract
    localparam int MOD_STEPS = 16;
    localparam int MCW       = $clog2(MOD_STEPS);
    // partial dividend: remainder so far with the next hash byte below it
    localparam int DW        = SW + 8;
    // floor(2^DW / SLOTS) stays below 2^9 for any slot count
    localparam int RECIP_I   = (1 << DW) / SLOTS;
    localparam logic [8:0]       RECIP     = 9'(RECIP_I);
    localparam logic [SW:0]      SLOTS_EXT = (SW + 1)'(SLOTS);
    localparam logic [MCW-1:0]   MCNT_LAST = MCW'(MOD_STEPS - 1);

    fnvlph_pkg::t_hash_state r_state, n_state;
    logic [63:0]                    r_h, n_h;
    logic [KW-1:0]                  r_key, n_key;
    logic [fnvlph_pkg::LEN_W-1:0]   r_left, n_left;
    logic [SW-1:0]                  r_rem, n_rem;
    logic [7:0]                     r_q, n_q;
    logic [MCW-1:0]                 r_mcnt, n_mcnt;
    logic [SW-1:0]                  r_home, n_home;
    logic [DW-1:0]                  mod_v;
    logic [DW+8:0]                  mod_p;
    logic [DW:0]                    mod_t;
    logic [7:0]                     q_est;
    logic [SW-1:0]                  rem_step;

    // remainder by reciprocal: the estimate is low by at most one, one fixup
    always_comb begin
        mod_v = {r_rem, r_h[63:56]};
        mod_p = (DW + 9)'(mod_v) * (DW + 9)'(RECIP);
        q_est = mod_p[DW+7:DW];
        mod_t = (DW + 1)'(mod_v) - (DW + 1)'(r_q) * (DW + 1)'(SLOTS_EXT);
        if (mod_t >= (DW + 1)'(SLOTS_EXT)) mod_t = mod_t - (DW + 1)'(SLOTS_EXT);
        rem_step = mod_t[SW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fnvlph_pkg::HS_IDLE: if (i_start) n_state = fnvlph_pkg::HS_MIX;
            fnvlph_pkg::HS_MIX: begin
                if (r_left == '0) n_state = IS_POW2 ? fnvlph_pkg::HS_DONE : fnvlph_pkg::HS_MOD;
            end
            fnvlph_pkg::HS_MOD: if (r_mcnt == MCNT_LAST) n_state = fnvlph_pkg::HS_DONE;
            fnvlph_pkg::HS_DONE: n_state = fnvlph_pkg::HS_IDLE;
            default: n_state = fnvlph_pkg::HS_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_h    = r_h;
        n_key  = r_key;
        n_left = r_left;
        n_rem  = r_rem;
        n_q    = r_q;
        n_mcnt = r_mcnt;
        n_home = r_home;
        case (r_state)
            fnvlph_pkg::HS_IDLE: begin
                if (i_start) begin
                    n_h    = fnvlph_pkg::FNV_BASIS;
                    n_key  = i_key;
                    n_left = i_len;
                end
            end
            fnvlph_pkg::HS_MIX: begin
                if (r_left != '0) begin
                    n_h    = fnvlph_pkg::fnv_mix(r_h, r_key[7:0]);
                    n_key  = r_key >> 8;
                    n_left = r_left - 1'b1;
                end else begin
                    // power-of-two table: home slot is the low hash bits
                    n_home = r_h[SW-1:0];
                    n_rem  = '0;
                    n_mcnt = '0;
                end
            end
            fnvlph_pkg::HS_MOD: begin
                n_mcnt = r_mcnt + 1'b1;
                if (!r_mcnt[0]) begin
                    n_q = q_est;
                end else begin
                    n_rem = rem_step;
                    n_h   = r_h << 8;
                    if (r_mcnt == MCNT_LAST) n_home = rem_step;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == fnvlph_pkg::HS_DONE);
        o_home = r_home;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnvlph_pkg::HS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_key  <= n_key;
        r_left <= n_left;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_mcnt <= n_mcnt;
        r_home <= n_home;
    end

endmodule

FILE: sv/fnvlph_store.sv
// Slot storage: tag memory (valid bit plus key) and value memory, one port each.
module fnvlph_store #(
    parameter int SLOTS      = fnvlph_pkg::SLOTS_DEF,
    parameter int KEY_BYTES  = fnvlph_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = fnvlph_pkg::VALUE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  fnvlph_pkg::t_store_ctl                        i_ctl,
    input  logic [$clog2(SLOTS)-1:0]                      i_addr,
    input  logic [8*KEY_BYTES-1:0]                        i_wr_key,
    input  logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] i_wr_val,
    output logic [8*KEY_BYTES:0]                          o_rd_tag,
    output logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] o_rd_val
);

    localparam int KW = 8 * KEY_BYTES;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [KW:0]   mem_tag [SLOTS];
    logic [VW-1:0] mem_val [SLOTS];
    logic [KW:0]   r_rd_tag;
    logic [VW-1:0] r_rd_val;

    // tag memory: clear touches only the valid bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            mem_tag[i_addr][KW] <= 1'b0;
        end else if (i_ctl.wr_tag) begin
            mem_tag[i_addr] <= {1'b1, i_wr_key};
        end
        if (i_ctl.rd) r_rd_tag <= mem_tag[i_addr];
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_val) mem_val[i_addr] <= i_wr_val;
        if (i_ctl.rd) r_rd_val <= mem_val[i_addr];
    end

    assign o_rd_tag = r_rd_tag;
    assign o_rd_val = r_rd_val;

endmodule

FILE: sv/fnv1a_linear_probe_hash_table_top.sv
// Top level: FNV-1a keyed hash table with linear probing over slot memories.
//
//  channel  dir  handshake                  payload
//  request  in   i_in_valid / o_in_stall    i_mode, i_key_bytes, i_value_in
//  result   out  o_out_valid / i_out_stall  o_status, o_value_out, o_slot
//
// A request runs its L key bytes through the hash unit, one byte per cycle,
// then makes P probes at one tag/value memory read per cycle.
// Slot counts that are not a power of two add remainder steps to the hash.
// A zero-value insert is answered without touching the table.
// After reset a clearing pass over all slots resets the valid bits first.
// A stalled result holds in the output register; the next request is
// still accepted and waits only at its own response step.
module fnv1a_linear_probe_hash_table_top #(
    parameter int SLOTS      = fnvlph_pkg::SLOTS_DEF,
    parameter int KEY_BYTES  = fnvlph_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = fnvlph_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [63:0] i_key_bytes,
    input  logic [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [9:0]  o_slot
);

`include "fnv1a_linear_probe_hash_table_top_macros.svh"

    localparam int KW = 8 * KEY_BYTES;
    localparam int SW = $clog2(SLOTS);
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    fnvlph_pkg::t_state     r_state, n_state;
    fnvlph_pkg::t_store_ctl ctl;

    logic [SW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_probes, n_probes;
    logic [CW-1:0] r_count, n_count;
    logic          r_mode, n_mode;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_val, n_val;
    logic [2:0]    r_res_status, n_res_status;
    logic [31:0]   r_res_value, n_res_value;
    logic [9:0]    r_res_slot, n_res_slot;
    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_o_status, n_o_status;
    logic [31:0]   r_o_value, n_o_value;
    logic [9:0]    r_o_slot, n_o_slot;

    logic [KW-1:0]                key_norm;
    logic [fnvlph_pkg::LEN_W-1:0] key_len;
    logic [VW-1:0]                val_c;
    logic                         zero_reject;
    logic                         in_accept;
    logic                         out_free;
    logic                         hash_done;
    logic [SW-1:0]                hash_home;
    logic [SW-1:0]                mem_addr;
    logic [KW:0]                  rd_tag;
    logic [VW-1:0]                rd_val;
    logic                         hit, empty, last_probe, probe_end;
    logic [SW-1:0]                idx_inc;

    // key normalization: keep bytes up to the first zero byte
    always_comb begin
        logic alive;
        alive    = 1'b1;
        key_norm = '0;
        key_len  = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (i_key_bytes[8*b +: 8] == 8'h00) alive = 1'b0;
            if (alive) begin
                key_norm[8*b +: 8] = i_key_bytes[8*b +: 8];
                key_len            = key_len + 1'b1;
            end
        end
    end

    assign val_c       = i_value_in[VW-1:0];
    assign zero_reject = (i_mode == fnvlph_pkg::MODE_INSERT) && (val_c == '0);
    assign in_accept   = i_in_valid && (r_state == fnvlph_pkg::ST_IDLE);
    assign out_free    = !r_o_valid || !i_out_stall;

    // probe decode on the registered memory read
    assign hit        = rd_tag[KW] && (rd_tag[KW-1:0] == r_key);
    assign empty      = !rd_tag[KW];
    assign last_probe = (r_probes == LAST_SLOT);
    assign probe_end  = hit || empty || last_probe;
    assign idx_inc    = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;

    fnvlph_hash #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept && !zero_reject),
        .i_key   (key_norm),
        .i_len   (key_len),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    fnvlph_store #(
        .SLOTS      (SLOTS),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_addr   (mem_addr),
        .i_wr_key (r_key),
        .i_wr_val (r_val),
        .o_rd_tag (rd_tag),
        .o_rd_val (rd_val)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fnvlph_pkg::ST_CLEAR: if (r_idx == LAST_SLOT) n_state = fnvlph_pkg::ST_IDLE;
            fnvlph_pkg::ST_IDLE: begin
                if (in_accept) n_state = zero_reject ? fnvlph_pkg::ST_RESP : fnvlph_pkg::ST_HASH;
            end
            fnvlph_pkg::ST_HASH:  if (hash_done) n_state = fnvlph_pkg::ST_READ;
            fnvlph_pkg::ST_READ:  n_state = fnvlph_pkg::ST_PROBE;
            fnvlph_pkg::ST_PROBE: if (probe_end) n_state = fnvlph_pkg::ST_RESP;
            fnvlph_pkg::ST_RESP:  if (out_free) n_state = fnvlph_pkg::ST_IDLE;
            default: n_state = fnvlph_pkg::ST_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        ctl        = '0;
        mem_addr   = r_idx;
        o_in_stall = (r_state != fnvlph_pkg::ST_IDLE);
        case (r_state)
            fnvlph_pkg::ST_CLEAR: ctl.clr = 1'b1;
            fnvlph_pkg::ST_READ:  ctl.rd  = 1'b1;
            fnvlph_pkg::ST_PROBE: begin
                if (!probe_end) begin
                    // keep probing: read the next slot right away
                    ctl.rd   = 1'b1;
                    mem_addr = idx_inc;
                end else if (r_mode == fnvlph_pkg::MODE_INSERT) begin
                    ctl.wr_tag = empty;
                    ctl.wr_val = hit || empty;
                end
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_idx        = r_idx;
        n_probes     = r_probes;
        n_count      = r_count;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_slot   = r_res_slot;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_value    = r_o_value;
        n_o_slot     = r_o_slot;
        case (r_state)
            fnvlph_pkg::ST_CLEAR: n_idx = idx_inc;
            fnvlph_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_mode       = i_mode;
                    n_key        = key_norm;
                    n_val        = val_c;
                    n_res_status = fnvlph_pkg::STAT_ZERO_VAL;
                    n_res_value  = '0;
                    n_res_slot   = '0;
                end
            end
            fnvlph_pkg::ST_HASH: begin
                if (hash_done) begin
                    n_idx    = hash_home;
                    n_probes = '0;
                end
            end
            fnvlph_pkg::ST_PROBE: begin
                if (!probe_end) begin
                    n_idx    = idx_inc;
                    n_probes = r_probes + 1'b1;
                end else begin
                    n_res_value = '0;
                    n_res_slot  = '0;
                    if (r_mode == fnvlph_pkg::MODE_LOOKUP) begin
                        if (hit) begin
                            n_res_status = fnvlph_pkg::STAT_FOUND;
                            n_res_value  = 32'(rd_val);
                            n_res_slot   = 10'(r_idx);
                        end else begin
                            n_res_status = fnvlph_pkg::STAT_NOT_FOUND;
                        end
                    end else if (hit) begin
                        n_res_status = fnvlph_pkg::STAT_REPLACED;
                        n_res_value  = 32'(rd_val);
                        n_res_slot   = 10'(r_idx);
                    end else if (empty) begin
                        n_res_status = fnvlph_pkg::STAT_INSERTED;
                        n_res_slot   = 10'(r_idx);
                        n_count      = r_count + 1'b1;
                    end else begin
                        n_res_status = fnvlph_pkg::STAT_FULL;
                    end
                end
            end
            fnvlph_pkg::ST_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_value  = r_res_value;
                    n_o_slot   = r_res_slot;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fnvlph_pkg::ST_CLEAR;
            r_idx     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_probes     <= n_probes;
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_value    <= n_o_value;
        r_o_slot     <= n_o_slot;
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_value_out = r_o_value;
    assign o_slot      = r_o_slot;

    // checks
    `FNVLPH_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(SLOTS), "entry count above slot count")
    `FNVLPH_ASSERT_NXT(a_count_inc, i_clk, i_rst_n, ctl.wr_tag, r_count == $past(r_count) + 1'b1, "insert did not bump entry count")
    `FNVLPH_ASSERT_IMP(a_tag_empty, i_clk, i_rst_n, ctl.wr_tag, !rd_tag[KW], "new key written over a valid slot")
    `FNVLPH_ASSERT_IMP(a_hash_state, i_clk, i_rst_n, hash_done, r_state == fnvlph_pkg::ST_HASH, "hash finished outside hash wait")

endmodule
